FILE: hdl/rps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route path statistics package
// Widths of the route totals and the status record of the serial units.
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int TOTAL_W = 40;
    localparam int SPEED_W = 16;
    localparam int COUNT_W = 16;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

FILE: hdl/rps_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial integer square root
// Restoring digit-by-digit root: two radicand bits enter and one root bit
// leaves per cycle, until all OUT_W root bits are formed.
// ----------------------------------------------------------------------------
module rps_isqrt #(
    parameter int IN_W = 50
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [IN_W-1:0]        i_val,
    output logic [IN_W/2-1:0]      o_root,
    output rps_pkg::t_unit_stat    o_stat
);
    import rps_pkg::*;

    localparam int OUT_W = IN_W / 2;
    localparam int CNT_W = $clog2(OUT_W + 1);

    logic [IN_W-1:0]  r_val;
    logic [OUT_W-1:0] r_rem;
    logic [OUT_W-1:0] r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [OUT_W+1:0] w_part;
    logic [OUT_W+1:0] w_trial;
    logic [OUT_W+1:0] w_diff;
    logic             w_ge;

    assign w_part  = {r_rem, r_val[IN_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_diff  = w_part - w_trial;
    assign w_ge    = (w_part >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(OUT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[IN_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[OUT_W-1:0] : w_part[OUT_W-1:0];
            r_root <= {r_root[OUT_W-2:0], w_ge};
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: hdl/rps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle. The dividend is left-aligned, and only the
// requested number of steps is run, so short dividends finish early.
// ----------------------------------------------------------------------------
module rps_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [$clog2(NUM_W+1)-1:0]     i_steps,
    input  logic [NUM_W-1:0]               i_num,
    input  logic [DEN_W-1:0]               i_den,
    output logic [NUM_W-1:0]               o_quo,
    output rps_pkg::t_unit_stat            o_stat
);
    import rps_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_quo       = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: hdl/route_path_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route path statistics
// Accumulates distance, travel time, speed range, average speed and point
// count over a route of points and emits one summary after the last point.
// ----------------------------------------------------------------------------
// The block works on one point at a time. The first point of a route is
// only stored. Every later point runs the bit-serial sum of squares, one
// multiplier bit per step, then the serial square root, one root bit per
// step, and then, unless the previous point's speed is zero, the serial
// divider for the segment time, one quotient bit per step. The last point
// then runs the same divider once more for the average speed, unless the
// total time is zero. A finished summary waits in the output register, and
// the next route may start while it waits.
module route_path_statistics #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // pos_x, pos_y, pos_z, point_speed, zero padding
    input  logic [((3*COORD_WIDTH+16+7)/8)*8-1:0]       s_axis_tdata,
    // is_last
    input  logic                                        s_axis_tlast,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // total_distance, total_time, max_speed, min_speed, avg_speed,
    // point_count
    output logic [2*rps_pkg::TOTAL_W+4*rps_pkg::SPEED_W-1:0] m_axis_tdata,
    // zero_speed_seen, saturated
    output logic [1:0]                                  m_axis_tuser
);
    import rps_pkg::*;

    localparam int CW         = COORD_WIDTH;
    localparam int SUM_W      = 2 * CW + 2;
    localparam int SQ_W       = (SUM_W > 64) ? 64 : SUM_W;
    localparam int LEN_W      = SQ_W / 2;
    localparam int SEG_NUM_W  = LEN_W + FRAC_BITS;
    localparam int DIV_NUM_W  = TOTAL_W + FRAC_BITS;
    localparam int STEP_W     = $clog2(DIV_NUM_W + 1);
    localparam int SQ_CNT_W   = $clog2(CW + 1);
    localparam int M_DATA_W   = 2 * TOTAL_W + 4 * SPEED_W;
    localparam int OFS_MAX    = 2 * TOTAL_W;
    localparam int OFS_MIN    = OFS_MAX + SPEED_W;
    localparam int OFS_COUNT  = OFS_MIN + 2 * SPEED_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_AVG  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // Route state.
    logic [2:0]          r_state, n_state;
    logic                r_go, n_go;
    logic [CW-1:0]       r_px, n_px;
    logic [CW-1:0]       r_py, n_py;
    logic [CW-1:0]       r_pz, n_pz;
    logic [SPEED_W-1:0]  r_pspeed, n_pspeed;
    logic                r_have, n_have;
    logic [TOTAL_W-1:0]  r_dist, n_dist;
    logic [TOTAL_W-1:0]  r_time, n_time;
    logic [SPEED_W-1:0]  r_smax, n_smax;
    logic [SPEED_W-1:0]  r_smin, n_smin;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_zero, n_zero;
    logic                r_sat, n_sat;
    logic                r_last, n_last;
    logic [SQ_CNT_W-1:0] r_sq_cnt, n_sq_cnt;
    logic                r_m_valid, n_m_valid;

    // Working registers.
    logic [SPEED_W-1:0]  r_seg_speed;
    logic [CW-1:0]       r_mx, r_my, r_mz;
    logic [CW-1:0]       r_bx, r_by, r_bz;
    logic [SUM_W-1:0]    r_acc;
    logic [SPEED_W-1:0]  r_avg;
    logic [M_DATA_W-1:0] r_m_data;
    logic [1:0]          r_m_user;

    logic [CW-1:0]       w_x, w_y, w_z;
    logic [SPEED_W-1:0]  w_spd;
    logic [CW:0]         w_dx, w_dy, w_dz;
    logic [CW-1:0]       w_ax, w_ay, w_az;
    logic [CW+1:0]       w_part;
    logic [SQ_W-1:0]     w_sq;
    logic                w_accept;
    logic                w_load;
    logic                w_root_go;
    logic                w_div_go;
    logic [LEN_W-1:0]    w_root;
    logic [DIV_NUM_W-1:0] w_num;
    logic [TOTAL_W-1:0]  w_den;
    logic [STEP_W-1:0]   w_steps;
    logic [DIV_NUM_W-1:0] w_quo;
    logic [TOTAL_W:0]    w_dist_sum;
    logic [TOTAL_W:0]    w_time_sum;
    t_unit_stat          w_root_stat;
    t_unit_stat          w_div_stat;

    assign w_x   = s_axis_tdata[0 +: CW];
    assign w_y   = s_axis_tdata[CW +: CW];
    assign w_z   = s_axis_tdata[2*CW +: CW];
    assign w_spd = s_axis_tdata[3*CW +: SPEED_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = !r_m_valid || m_axis_tready;

    assign w_dx = {w_x[CW-1], w_x} - {r_px[CW-1], r_px};
    assign w_dy = {w_y[CW-1], w_y} - {r_py[CW-1], r_py};
    assign w_dz = {w_z[CW-1], w_z} - {r_pz[CW-1], r_pz};
    assign w_ax = w_dx[CW] ? CW'(-w_dx) : w_dx[CW-1:0];
    assign w_ay = w_dy[CW] ? CW'(-w_dy) : w_dy[CW-1:0];
    assign w_az = w_dz[CW] ? CW'(-w_dz) : w_dz[CW-1:0];

    // One multiplier bit of each square enters per cycle, most significant
    // bit first.
    assign w_part = (CW+2)'(r_mx & {CW{r_bx[CW-1]}})
                  + (CW+2)'(r_my & {CW{r_by[CW-1]}})
                  + (CW+2)'(r_mz & {CW{r_bz[CW-1]}});

    if (SUM_W > SQ_W) begin : g_sq_sat
        assign w_sq = (|r_acc[SUM_W-1:SQ_W]) ? '1 : r_acc[SQ_W-1:0];
    end else begin : g_sq_plain
        assign w_sq = r_acc;
    end

    assign w_root_go = r_go && (r_state == ST_ROOT);
    assign w_div_go  = r_go && ((r_state == ST_DIV) || (r_state == ST_AVG));

    always_comb begin
        if (r_state == ST_AVG) begin
            w_num   = DIV_NUM_W'(r_dist) << FRAC_BITS;
            w_den   = r_time;
            w_steps = STEP_W'(DIV_NUM_W);
        end else begin
            w_num   = DIV_NUM_W'(w_root) << (DIV_NUM_W - LEN_W);
            w_den   = TOTAL_W'(r_seg_speed);
            w_steps = STEP_W'(SEG_NUM_W);
        end
    end

    rps_isqrt #(
        .IN_W (SQ_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_go),
        .i_val   (w_sq),
        .o_root  (w_root),
        .o_stat  (w_root_stat)
    );

    rps_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (TOTAL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_steps (w_steps),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quo   (w_quo),
        .o_stat  (w_div_stat)
    );

    assign w_dist_sum = {1'b0, r_dist} + (TOTAL_W+1)'(w_root);
    assign w_time_sum = {1'b0, r_time} + {1'b0, w_quo[TOTAL_W-1:0]};

    always_comb begin
        n_state   = r_state;
        n_go      = 1'b0;
        n_px      = r_px;
        n_py      = r_py;
        n_pz      = r_pz;
        n_pspeed  = r_pspeed;
        n_have    = r_have;
        n_dist    = r_dist;
        n_time    = r_time;
        n_smax    = r_smax;
        n_smin    = r_smin;
        n_count   = r_count;
        n_zero    = r_zero;
        n_sat     = r_sat;
        n_last    = r_last;
        n_sq_cnt  = r_sq_cnt;
        n_m_valid = r_m_valid && !m_axis_tready;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_px     = w_x;
                    n_py     = w_y;
                    n_pz     = w_z;
                    n_pspeed = w_spd;
                    n_have   = 1'b1;
                    n_last   = s_axis_tlast;
                    if (w_spd > r_smax) begin
                        n_smax = w_spd;
                    end
                    if (w_spd < r_smin) begin
                        n_smin = w_spd;
                    end
                    if (r_count == '1) begin
                        n_sat = 1'b1;
                    end else begin
                        n_count = r_count + COUNT_W'(1);
                    end
                    if (r_have) begin
                        n_sq_cnt = SQ_CNT_W'(CW);
                        n_state  = ST_SQ;
                    end else if (s_axis_tlast) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_SQ: begin
                n_sq_cnt = r_sq_cnt - SQ_CNT_W'(1);
                if (r_sq_cnt == SQ_CNT_W'(1)) begin
                    n_go    = 1'b1;
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (w_root_stat.done) begin
                    if (w_dist_sum[TOTAL_W]) begin
                        n_dist = '1;
                        n_sat  = 1'b1;
                    end else begin
                        n_dist = w_dist_sum[TOTAL_W-1:0];
                    end
                    if (r_seg_speed == '0) begin
                        n_zero  = 1'b1;
                        n_state = r_last ? ST_FIN : ST_IDLE;
                    end else begin
                        n_go    = 1'b1;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    if (w_time_sum[TOTAL_W]) begin
                        n_time = '1;
                        n_sat  = 1'b1;
                    end else begin
                        n_time = w_time_sum[TOTAL_W-1:0];
                    end
                    n_state = r_last ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                if (r_time == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_go    = 1'b1;
                    n_state = ST_AVG;
                end
            end
            ST_AVG: begin
                if (w_div_stat.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_load) begin
                    n_m_valid = 1'b1;
                    n_px      = '0;
                    n_py      = '0;
                    n_pz      = '0;
                    n_pspeed  = '0;
                    n_have    = 1'b0;
                    n_dist    = '0;
                    n_time    = '0;
                    n_smax    = '0;
                    n_smin    = '1;
                    n_count   = '0;
                    n_zero    = 1'b0;
                    n_sat     = 1'b0;
                    n_last    = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_go      <= 1'b0;
            r_px      <= '0;
            r_py      <= '0;
            r_pz      <= '0;
            r_pspeed  <= '0;
            r_have    <= 1'b0;
            r_dist    <= '0;
            r_time    <= '0;
            r_smax    <= '0;
            r_smin    <= '1;
            r_count   <= '0;
            r_zero    <= 1'b0;
            r_sat     <= 1'b0;
            r_last    <= 1'b0;
            r_sq_cnt  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_go      <= n_go;
            r_px      <= n_px;
            r_py      <= n_py;
            r_pz      <= n_pz;
            r_pspeed  <= n_pspeed;
            r_have    <= n_have;
            r_dist    <= n_dist;
            r_time    <= n_time;
            r_smax    <= n_smax;
            r_smin    <= n_smin;
            r_count   <= n_count;
            r_zero    <= n_zero;
            r_sat     <= n_sat;
            r_last    <= n_last;
            r_sq_cnt  <= n_sq_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && r_have) begin
            r_seg_speed <= r_pspeed;
            r_mx        <= w_ax;
            r_my        <= w_ay;
            r_mz        <= w_az;
            r_bx        <= w_ax;
            r_by        <= w_ay;
            r_bz        <= w_az;
            r_acc       <= '0;
        end else if (r_state == ST_SQ) begin
            r_bx  <= {r_bx[CW-2:0], 1'b0};
            r_by  <= {r_by[CW-2:0], 1'b0};
            r_bz  <= {r_bz[CW-2:0], 1'b0};
            r_acc <= {r_acc[SUM_W-2:0], 1'b0} + SUM_W'(w_part);
        end
        if (r_state == ST_FIN) begin
            r_avg <= '0;
        end else if ((r_state == ST_AVG) && w_div_stat.done) begin
            r_avg <= (|w_quo[DIV_NUM_W-1:SPEED_W]) ? '1 : w_quo[SPEED_W-1:0];
        end
        if ((r_state == ST_OUT) && w_load) begin
            r_m_data <= {r_count, r_avg, r_smin, r_smax, r_time, r_dist};
            r_m_user <= {r_sat, r_zero};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    a_units_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_root_stat.busy && !w_div_stat.busy)
        else $error("A serial unit is busy while the block takes a new point.");

    a_root_done_in_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_stat.done |-> (r_state == ST_ROOT))
        else $error("Square root finished outside its state.");

    a_div_done_in_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == ST_DIV) || (r_state == ST_AVG))
        else $error("Divider finished outside its states.");

    a_route_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && w_load |=> !r_have && (r_count == '0) && r_m_valid)
        else $error("Route state was not cleared after the summary transfer.");

    a_summary_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_data[OFS_COUNT +: COUNT_W] != '0)
            && (r_m_data[OFS_MIN +: SPEED_W] <= r_m_data[OFS_MAX +: SPEED_W]))
        else $error("Summary holds no points or an inverted speed range.");

endmodule
